// File: rtl/core/bule_pkg.sv
// Package for the bounded unique list engine: command and status codes,
// the command queue transaction type and the executor state type. No dependencies.
`default_nettype none
package bule_pkg;
    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_APPEND    = 3'd1,
        CMD_INS_SORT  = 3'd2,
        CMD_SEARCH    = 3'd3,
        CMD_MODIFY    = 3'd4,
        CMD_DELETE    = 3'd5,
        CMD_SORT      = 3'd6,
        CMD_NOP       = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_PRESENT = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] value;
        logic [31:0] new_value;
    } req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_SORT,
        S_SCAN,
        S_SHR,
        S_SHL,
        S_DONE
    } state_t;
endpackage
`default_nettype wire

// File: rtl/core/bule_front.sv
// Front end: a two-entry command queue between the push side and the executor.
// Depends on bule_pkg.
`default_nettype none
module bule_front
    import bule_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire req_t  req_in,
    output logic       req_valid,
    input  wire logic  req_take,
    output req_t       req_out
);
    req_t       slot_reg [2];
    logic       rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign full      = (cnt_reg == 2'd2);
    assign req_valid = (cnt_reg != 2'd0);
    assign req_out   = slot_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = req_take && req_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= req_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push) wr_reg <= !wr_reg;
            if (do_pop)  rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/bule_exec.sv
// Back end: list store and sequencer that walks entries one per cycle,
// plus a one-entry result register. Depends on bule_pkg.
`default_nettype none
module bule_exec
    import bule_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_take,
    input  wire req_t    req,
    output logic         empty,
    input  wire logic    pop,
    output logic [1:0]   status,
    output logic [3:0]   position,
    output logic [4:0]   count
);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    // at least as wide as the count port so the result slices always exist
    localparam int CW = ($clog2(CAPACITY + 1) > 5) ? $clog2(CAPACITY + 1) : 5;

    logic [31:0]   mem [CAPACITY];
    state_t        state_reg, state_next;
    req_t          cur_reg, cur_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;    // walk pointer
    logic [CW-1:0] lim_reg, lim_next;    // sort pass limit
    logic          swp_reg, swp_next;    // swap seen in this pass
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] k_reg, k_next;
    logic          rv_reg;
    logic [1:0]    rs_reg;
    logic [3:0]    rp_reg;
    logic [4:0]    rc_reg;

    logic          mw_en;
    logic [IW-1:0] mw_addr;
    logic [31:0]   mw_data;
    logic          mw2_en;
    logic [IW-1:0] mw2_addr;
    logic [31:0]   mw2_data;
    logic          res_load;
    status_t       res_st;
    logic [CW-1:0] res_pos;

    logic [31:0]   ra, rb;
    logic [IW-1:0] ia, ib;
    logic          is_ins;

    assign ia = idx_reg[IW-1:0];
    assign ib = ia + IW'(1);
    assign ra = mem[ia];
    assign rb = mem[ib];
    assign is_ins = (cur_reg.cmd == CMD_INS_FRONT) || (cur_reg.cmd == CMD_APPEND)
                 || (cur_reg.cmd == CMD_INS_SORT);

    assign empty    = !rv_reg;
    assign status   = rs_reg;
    assign position = rp_reg;
    assign count    = rc_reg;

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        lim_next   = lim_reg;
        swp_next   = swp_reg;
        pos_next   = pos_reg;
        k_next     = k_reg;
        req_take   = 1'b0;
        mw_en = 1'b0; mw_addr = ia; mw_data = ra;
        mw2_en = 1'b0; mw2_addr = ib; mw2_data = rb;
        res_load = 1'b0; res_st = ST_OK; res_pos = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && !rv_reg)
                begin
                    req_take = 1'b1;
                    cur_next = req;
                    idx_next = '0;
                    case (req.cmd)
                        CMD_INS_FRONT, CMD_APPEND, CMD_INS_SORT:
                        begin
                            if (cnt_reg == CW'(CAPACITY))
                            begin
                                res_load = 1'b1; res_st = ST_FULL;
                            end
                            else
                            begin
                                state_next = S_FIND;
                            end
                        end
                        CMD_SEARCH, CMD_MODIFY, CMD_DELETE: state_next = S_FIND;
                        CMD_SORT:
                        begin
                            lim_next = cnt_reg; swp_next = 1'b0; state_next = S_SORT;
                        end
                        default: res_load = 1'b1;
                    endcase
                end
            end
            S_FIND:
            begin
                if (idx_reg == cnt_reg)
                begin
                    // not present
                    if (!is_ins)
                    begin
                        res_load = 1'b1; res_st = ST_MISSING; state_next = S_IDLE;
                    end
                    else if (cur_reg.cmd == CMD_INS_FRONT)
                    begin
                        pos_next = '0; k_next = cnt_reg; state_next = S_SHR;
                    end
                    else if (cur_reg.cmd == CMD_APPEND)
                    begin
                        pos_next = cnt_reg; k_next = cnt_reg; state_next = S_SHR;
                    end
                    else
                    begin
                        idx_next = '0; lim_next = cnt_reg; swp_next = 1'b0;
                        state_next = S_SORT;
                    end
                end
                else if (ra == cur_reg.value)
                begin
                    pos_next = idx_reg;
                    case (cur_reg.cmd)
                        CMD_SEARCH:
                        begin
                            res_load = 1'b1; res_pos = idx_reg; state_next = S_IDLE;
                        end
                        CMD_MODIFY:
                        begin
                            mw_en = 1'b1; mw_data = cur_reg.new_value;
                            res_load = 1'b1; res_pos = idx_reg; state_next = S_IDLE;
                        end
                        CMD_DELETE: state_next = S_SHL;
                        default:
                        begin
                            res_load = 1'b1; res_st = ST_PRESENT; state_next = S_IDLE;
                        end
                    endcase
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_SORT:
            begin
                // one compare-swap of neighbours per cycle; pass ends at lim
                if (lim_reg <= CW'(1) || idx_reg + CW'(1) >= lim_reg)
                begin
                    if (lim_reg <= CW'(1) || !swp_reg)
                    begin
                        if (cur_reg.cmd == CMD_SORT)
                        begin
                            res_load = 1'b1; state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next = '0; state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        lim_next = lim_reg - CW'(1); idx_next = '0; swp_next = 1'b0;
                    end
                end
                else
                begin
                    if ($signed(rb) < $signed(ra))
                    begin
                        mw_en = 1'b1; mw_data = rb;
                        mw2_en = 1'b1; mw2_data = ra;
                        swp_next = 1'b1;
                    end
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_SCAN:
            begin
                if (idx_reg < cnt_reg && $signed(ra) < $signed(cur_reg.value))
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    pos_next = idx_reg; k_next = cnt_reg; state_next = S_SHR;
                end
            end
            S_SHR:
            begin
                if (k_reg == pos_reg)
                begin
                    mw_en = 1'b1; mw_addr = pos_reg[IW-1:0]; mw_data = cur_reg.value;
                    cnt_next = cnt_reg + CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    mw_en = 1'b1; mw_addr = k_reg[IW-1:0];
                    mw_data = mem[k_reg[IW-1:0] - IW'(1)];
                    k_next = k_reg - CW'(1);
                end
            end
            S_SHL:
            begin
                if (idx_reg + CW'(1) >= cnt_reg)
                begin
                    cnt_next = cnt_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    mw_en = 1'b1; mw_data = rb;
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                res_load = 1'b1; res_pos = pos_reg; state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mw_en)  mem[mw_addr]  <= mw_data;
        if (mw2_en) mem[mw2_addr] <= mw2_data;
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        lim_reg <= lim_next;
        swp_reg <= swp_next;
        pos_reg <= pos_next;
        k_reg   <= k_next;
        if (res_load)
        begin
            rs_reg <= res_st;
            rp_reg <= (res_st == ST_OK) ? res_pos[3:0] : 4'd0;
            rc_reg <= (state_reg == S_DONE) ? cnt_reg[4:0] : cnt_next[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (res_load)          rv_reg <= 1'b1;
            else if (pop && rv_reg) rv_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/bounded_unique_list_engine_core.sv
// Top level of the bounded unique list engine: command queue front end and
// sequenced list executor. Depends on bule_pkg, bule_front, bule_exec.
`default_nettype none
// Bounded list of unique signed 32-bit values. Each pushed transaction
// (command, value, new_value) yields exactly one result (status, position,
// count), in order. A two-entry command queue takes transactions while the
// executor works; the executor holds the list in a CAPACITY-entry store and
// walks it one entry per cycle. Search and modify scan for the value; delete
// and inserts scan, then shift entries; sort (and sorted insert) runs a bubble
// sort at one compare-swap per cycle. A new command starts once the previous
// result has been popped.
module bounded_unique_list_engine_core
    import bule_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  command,
    input  wire logic signed [31:0] value,
    input  wire logic signed [31:0] new_value,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       status,
    output logic [3:0]       position,
    output logic [4:0]       count
);
    req_t req_in, req_q;
    logic req_valid, req_take;

    assign req_in.cmd       = cmd_t'(command);
    assign req_in.value     = value;
    assign req_in.new_value = new_value;

    bule_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .req_in(req_in),
        .req_valid(req_valid), .req_take(req_take), .req_out(req_q)
    );

    bule_exec #(.CAPACITY(CAPACITY)) u_exec (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_take(req_take),
        .req(req_q), .empty(empty), .pop(pop), .status(status),
        .position(position), .count(count)
    );
endmodule
`default_nettype wire
